@@ sv/aads_pkg.sv @@
// Shared types and constants of the area-average downscaler.
package aads_pkg;

    // Channel and field widths.
    localparam int PIX_W = 8;
    localparam int NUM_CH = 3;
    localparam int POS_W = 11;
    localparam int COL_W = 12;
    localparam int WT_W = 12;
    localparam int SPROD_W = 26;
    localparam int PROD_W = 32;
    localparam int DIV_STEPS = 10;
    localparam int DST_ROW_LIMIT = 2048;

    typedef logic [12:0] sdim_t;
    typedef logic [11:0] ddim_t;
    typedef logic [SPROD_W-1:0] sprod_t;
    typedef logic [2*WT_W-1:0] wprod_t;
    typedef logic [PROD_W-1:0] prod_t;

    // Register reset values.
    localparam sdim_t RST_SRC_WIDTH = 13'd2560;
    localparam sdim_t RST_SRC_HEIGHT = 13'd1920;
    localparam ddim_t RST_DST_WIDTH = 12'd1280;
    localparam ddim_t RST_DST_HEIGHT = 12'd960;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_DST_WIDTH  = 2'd2,
        REG_DST_HEIGHT = 2'd3
    } cfg_reg_t;

    // One classified source pixel, passed from the front to the back.
    typedef struct packed {
        logic [NUM_CH-1:0][PIX_W-1:0] pix;
        logic [WT_W-1:0] wx0;
        logic [WT_W-1:0] wx1;
        logic [WT_W-1:0] wy0;
        logic [WT_W-1:0] wy1;
        logic [COL_W-1:0] col;
        logic bank;
        logic emit;
        logic [POS_W-1:0] out_col;
        logic [POS_W-1:0] out_row;
        logic frame_last;
    } cmd_t;

    // Back-end sequencer states.
    typedef enum logic [3:0] {
        BK_CLEAR = 4'd0,
        BK_IDLE  = 4'd1,
        BK_RD0   = 4'd2,
        BK_MUL0  = 4'd3,
        BK_ADD0  = 4'd4,
        BK_RD1   = 4'd5,
        BK_MUL1  = 4'd6,
        BK_ADD1  = 4'd7,
        BK_DIV   = 4'd8,
        BK_OUT   = 4'd9
    } back_state_t;

endpackage

@@ sv/aads_front.sv @@
// Front end: configuration registers, raster counters and pixel classification.
module aads_front #(
    parameter int MAX_DST_WIDTH = 2048,
    parameter int MAX_SRC_DIM = 4096
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_wr_en,
    input  aads_pkg::cfg_reg_t cfg_index,
    input  logic [12:0] cfg_data,
    input  logic pix_accept,
    input  logic [7:0] pix_red,
    input  logic [7:0] pix_green,
    input  logic [7:0] pix_blue,
    output aads_pkg::cmd_t cmd,
    output aads_pkg::sprod_t s_prod
);

    aads_pkg::sdim_t src_width_reg, src_height_reg;
    aads_pkg::ddim_t dst_width_reg, dst_height_reg;
    aads_pkg::sdim_t src_col_reg, src_col_next, src_row_reg, src_row_next;
    aads_pkg::sdim_t col_phase_reg, col_phase_next, row_phase_reg, row_phase_next;
    logic [aads_pkg::COL_W-1:0] dst_col_reg, dst_col_next;
    logic [aads_pkg::POS_W-1:0] dst_row_reg, dst_row_next;
    aads_pkg::sprod_t s_prod_reg;

    aads_pkg::sdim_t sw, sh;
    aads_pkg::ddim_t dw_c, dh_c, dw, dh;
    logic [13:0] xend, yend;
    logic col_done, row_done, row_end, frame_end;
    logic [aads_pkg::WT_W-1:0] wx0, wx1, wy0, wy1;

    // Clamp the programmed sizes to the supported ranges.
    always_comb
    begin
        if (src_width_reg == '0)
            sw = aads_pkg::sdim_t'(1);
        else if (32'(src_width_reg) > MAX_SRC_DIM)
            sw = aads_pkg::sdim_t'(MAX_SRC_DIM);
        else
            sw = src_width_reg;
        if (src_height_reg == '0)
            sh = aads_pkg::sdim_t'(1);
        else if (32'(src_height_reg) > MAX_SRC_DIM)
            sh = aads_pkg::sdim_t'(MAX_SRC_DIM);
        else
            sh = src_height_reg;
        if (dst_width_reg == '0)
            dw_c = aads_pkg::ddim_t'(1);
        else if (32'(dst_width_reg) > MAX_DST_WIDTH)
            dw_c = aads_pkg::ddim_t'(MAX_DST_WIDTH);
        else
            dw_c = dst_width_reg;
        if (dst_height_reg == '0)
            dh_c = aads_pkg::ddim_t'(1);
        else if (32'(dst_height_reg) > aads_pkg::DST_ROW_LIMIT)
            dh_c = aads_pkg::ddim_t'(aads_pkg::DST_ROW_LIMIT);
        else
            dh_c = dst_height_reg;
        dw = ({1'b0, dw_c} > sw) ? sw[11:0] : dw_c;
        dh = ({1'b0, dh_c} > sh) ? sh[11:0] : dh_c;
    end

    // Split the pixel's footprint between two destination columns and rows.
    always_comb
    begin
        xend = {1'b0, col_phase_reg} + 14'(dw);
        col_done = xend >= 14'(sw);
        wx0 = aads_pkg::WT_W'((col_done ? 14'(sw) : xend) - 14'(col_phase_reg));
        wx1 = (xend > 14'(sw)) ? aads_pkg::WT_W'(xend - 14'(sw)) : '0;
        yend = {1'b0, row_phase_reg} + 14'(dh);
        row_done = yend >= 14'(sh);
        wy0 = aads_pkg::WT_W'((row_done ? 14'(sh) : yend) - 14'(row_phase_reg));
        wy1 = (yend > 14'(sh)) ? aads_pkg::WT_W'(yend - 14'(sh)) : '0;
        row_end = (14'(src_col_reg) + 14'd1) >= 14'(sw);
        frame_end = row_end && ((14'(src_row_reg) + 14'd1) >= 14'(sh));
    end

    // Command for the back end.
    always_comb
    begin
        cmd.pix[0] = pix_red;
        cmd.pix[1] = pix_green;
        cmd.pix[2] = pix_blue;
        cmd.wx0 = wx0;
        cmd.wx1 = wx1;
        cmd.wy0 = wy0;
        cmd.wy1 = wy1;
        cmd.col = dst_col_reg;
        cmd.bank = dst_row_reg[0];
        cmd.emit = col_done && row_done;
        cmd.out_col = aads_pkg::POS_W'(dst_col_reg);
        cmd.out_row = dst_row_reg;
        cmd.frame_last = frame_end;
    end

    // Raster counters advance on every accepted transfer and restart on a configuration write.
    always_comb
    begin
        src_col_next = src_col_reg;
        src_row_next = src_row_reg;
        dst_col_next = dst_col_reg;
        dst_row_next = dst_row_reg;
        col_phase_next = col_phase_reg;
        row_phase_next = row_phase_reg;
        if (cfg_wr_en || (pix_accept && frame_end))
        begin
            src_col_next = '0;
            src_row_next = '0;
            dst_col_next = '0;
            dst_row_next = '0;
            col_phase_next = '0;
            row_phase_next = '0;
        end
        else if (pix_accept && row_end)
        begin
            src_col_next = '0;
            dst_col_next = '0;
            col_phase_next = '0;
            src_row_next = src_row_reg + 13'd1;
            if (row_done)
            begin
                dst_row_next = dst_row_reg + 11'd1;
                row_phase_next = 13'(yend - 14'(sh));
            end
            else
            begin
                row_phase_next = 13'(yend);
            end
        end
        else if (pix_accept)
        begin
            src_col_next = src_col_reg + 13'd1;
            if (col_done)
            begin
                dst_col_next = dst_col_reg + 12'd1;
                col_phase_next = 13'(xend - 14'(sw));
            end
            else
            begin
                col_phase_next = 13'(xend);
            end
        end
    end

    // Configuration registers and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg <= aads_pkg::RST_SRC_WIDTH;
            src_height_reg <= aads_pkg::RST_SRC_HEIGHT;
            dst_width_reg <= aads_pkg::RST_DST_WIDTH;
            dst_height_reg <= aads_pkg::RST_DST_HEIGHT;
            src_col_reg <= '0;
            src_row_reg <= '0;
            dst_col_reg <= '0;
            dst_row_reg <= '0;
            col_phase_reg <= '0;
            row_phase_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    aads_pkg::REG_SRC_WIDTH:  src_width_reg <= cfg_data;
                    aads_pkg::REG_SRC_HEIGHT: src_height_reg <= cfg_data;
                    aads_pkg::REG_DST_WIDTH:  dst_width_reg <= cfg_data[11:0];
                    aads_pkg::REG_DST_HEIGHT: dst_height_reg <= cfg_data[11:0];
                    default: ;
                endcase
            end
            src_col_reg <= src_col_next;
            src_row_reg <= src_row_next;
            dst_col_reg <= dst_col_next;
            dst_row_reg <= dst_row_next;
            col_phase_reg <= col_phase_next;
            row_phase_reg <= row_phase_next;
        end
    end

    // Source area, used as the divisor scale.
    always_ff @(posedge clk)
    begin
        s_prod_reg <= aads_pkg::sprod_t'(sw) * aads_pkg::sprod_t'(sh);
    end

    assign s_prod = s_prod_reg;

endmodule

@@ sv/aads_queue.sv @@
// Two-entry command queue between the front and the back.
module aads_queue (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  aads_pkg::cmd_t push_data,
    input  logic pop,
    output aads_pkg::cmd_t pop_data,
    output logic full,
    output logic empty
);

    aads_pkg::cmd_t slot_reg [2];
    logic wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    assign pop_data = slot_reg[rd_ptr_reg];
    assign full = count_reg == 2'd2;
    assign empty = count_reg == 2'd0;

endmodule

@@ sv/aads_back.sv @@
// Back end: accumulator banks, weighted adds, rounding divider and output register.
module aads_back #(
    parameter int MAX_DST_WIDTH = 2048,
    parameter int ACC_BITS = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic clear_start,
    input  logic q_empty,
    input  aads_pkg::cmd_t q_data,
    input  aads_pkg::sprod_t s_prod,
    output logic q_pop,
    output logic clearing,
    output logic out_valid,
    input  logic out_ready,
    output logic [7:0] out_red,
    output logic [7:0] out_green,
    output logic [7:0] out_blue,
    output logic [10:0] out_col,
    output logic [10:0] out_row,
    output logic frame_last
);

    localparam int IDXW = (MAX_DST_WIDTH > 1) ? $clog2(MAX_DST_WIDTH) : 1;
    localparam int ROWW = aads_pkg::NUM_CH * ACC_BITS;
    localparam int SUMW = ((ACC_BITS > aads_pkg::PROD_W) ? ACC_BITS : aads_pkg::PROD_W) + 1;
    localparam int NUMW = ((ACC_BITS + 1 > aads_pkg::SPROD_W) ?
                           ACC_BITS + 1 : aads_pkg::SPROD_W) + 1;
    localparam int DSHW = aads_pkg::SPROD_W + aads_pkg::DIV_STEPS;
    localparam int DIVW = (NUMW > DSHW) ? NUMW : DSHW;
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(MAX_DST_WIDTH - 1);
    localparam logic [SUMW-1:0] ACC_LIM = SUMW'({ACC_BITS{1'b1}});

    aads_pkg::back_state_t state_reg, state_next;
    aads_pkg::cmd_t cmd_reg;
    logic [IDXW-1:0] clr_cnt_reg;
    logic [3:0] div_cnt_reg;
    logic [ROWW-1:0] mem_a_reg [MAX_DST_WIDTH];
    logic [ROWW-1:0] mem_b_reg [MAX_DST_WIDTH];
    logic [ROWW-1:0] rd_a_reg, rd_b_reg;
    aads_pkg::wprod_t wa_reg, wb_reg;
    aads_pkg::prod_t pa_reg [aads_pkg::NUM_CH];
    aads_pkg::prod_t pb_reg [aads_pkg::NUM_CH];
    logic [DIVW-1:0] num_reg [aads_pkg::NUM_CH];
    logic [DIVW-1:0] dsh_reg;
    logic [aads_pkg::DIV_STEPS-1:0] q_reg [aads_pkg::NUM_CH];
    logic out_valid_reg;
    logic [7:0] res_reg [aads_pkg::NUM_CH];
    logic [10:0] out_col_reg, out_row_reg;
    logic out_last_reg;

    logic mem_we, second_col, emit_cap, div_step, out_load;
    logic [IDXW-1:0] mem_addr;
    logic [ROWW-1:0] wd_a, wd_b, cur_rd, nxt_rd, cur_wd, nxt_wd;
    logic [SUMW-1:0] cur_sum [aads_pkg::NUM_CH];
    logic [SUMW-1:0] nxt_sum [aads_pkg::NUM_CH];
    logic [aads_pkg::WT_W-1:0] wx_sel;

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            aads_pkg::BK_CLEAR: if (clr_cnt_reg == LAST_IDX) state_next = aads_pkg::BK_IDLE;
            aads_pkg::BK_IDLE:  if (!q_empty) state_next = aads_pkg::BK_RD0;
            aads_pkg::BK_RD0:   state_next = aads_pkg::BK_MUL0;
            aads_pkg::BK_MUL0:  state_next = aads_pkg::BK_ADD0;
            aads_pkg::BK_ADD0:
            begin
                if (cmd_reg.wx1 != '0)
                    state_next = aads_pkg::BK_RD1;
                else if (cmd_reg.emit)
                    state_next = aads_pkg::BK_DIV;
                else
                    state_next = aads_pkg::BK_IDLE;
            end
            aads_pkg::BK_RD1:   state_next = aads_pkg::BK_MUL1;
            aads_pkg::BK_MUL1:  state_next = aads_pkg::BK_ADD1;
            aads_pkg::BK_ADD1:
                state_next = cmd_reg.emit ? aads_pkg::BK_DIV : aads_pkg::BK_IDLE;
            aads_pkg::BK_DIV:   if (div_cnt_reg == 4'd0) state_next = aads_pkg::BK_OUT;
            aads_pkg::BK_OUT:
                if (!out_valid_reg || out_ready) state_next = aads_pkg::BK_IDLE;
            default: state_next = aads_pkg::BK_CLEAR;
        endcase
        if (clear_start)
            state_next = aads_pkg::BK_CLEAR;
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        clearing = state_reg == aads_pkg::BK_CLEAR;
        q_pop = (state_reg == aads_pkg::BK_IDLE) && !q_empty && !clear_start;
        second_col = (state_reg == aads_pkg::BK_RD1) || (state_reg == aads_pkg::BK_MUL1) ||
                     (state_reg == aads_pkg::BK_ADD1);
        mem_we = clearing || (state_reg == aads_pkg::BK_ADD0) ||
                 (state_reg == aads_pkg::BK_ADD1);
        emit_cap = (state_reg == aads_pkg::BK_ADD0) && cmd_reg.emit;
        div_step = state_reg == aads_pkg::BK_DIV;
        out_load = (state_reg == aads_pkg::BK_OUT) && (!out_valid_reg || out_ready);
        if (clearing)
            mem_addr = clr_cnt_reg;
        else if (second_col)
            mem_addr = IDXW'(cmd_reg.col + 12'd1);
        else
            mem_addr = IDXW'(cmd_reg.col);
        wx_sel = second_col ? cmd_reg.wx1 : cmd_reg.wx0;
    end

    // Saturating adds; the current row entry is zeroed when it is emitted.
    always_comb
    begin
        cur_rd = cmd_reg.bank ? rd_b_reg : rd_a_reg;
        nxt_rd = cmd_reg.bank ? rd_a_reg : rd_b_reg;
        for (int k = 0; k < aads_pkg::NUM_CH; k++)
        begin
            cur_sum[k] = SUMW'(cur_rd[k*ACC_BITS +: ACC_BITS]) + SUMW'(pa_reg[k]);
            if (cur_sum[k] > ACC_LIM)
                cur_sum[k] = ACC_LIM;
            nxt_sum[k] = SUMW'(nxt_rd[k*ACC_BITS +: ACC_BITS]) + SUMW'(pb_reg[k]);
            if (nxt_sum[k] > ACC_LIM)
                nxt_sum[k] = ACC_LIM;
            cur_wd[k*ACC_BITS +: ACC_BITS] = emit_cap ? '0 : ACC_BITS'(cur_sum[k]);
            nxt_wd[k*ACC_BITS +: ACC_BITS] = ACC_BITS'(nxt_sum[k]);
        end
        if (clearing)
        begin
            wd_a = '0;
            wd_b = '0;
        end
        else
        begin
            wd_a = cmd_reg.bank ? nxt_wd : cur_wd;
            wd_b = cmd_reg.bank ? cur_wd : nxt_wd;
        end
    end

    // Accumulator banks, one per destination row parity.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_a_reg[mem_addr] <= wd_a;
            mem_b_reg[mem_addr] <= wd_b;
        end
        rd_a_reg <= mem_a_reg[mem_addr];
        rd_b_reg <= mem_b_reg[mem_addr];
    end

    // Weight products, then color products, one multiply level per cycle.
    always_ff @(posedge clk)
    begin
        if (q_pop)
            cmd_reg <= q_data;
        wa_reg <= aads_pkg::wprod_t'(wx_sel) * aads_pkg::wprod_t'(cmd_reg.wy0);
        wb_reg <= aads_pkg::wprod_t'(wx_sel) * aads_pkg::wprod_t'(cmd_reg.wy1);
        for (int k = 0; k < aads_pkg::NUM_CH; k++)
        begin
            pa_reg[k] <= aads_pkg::prod_t'(cmd_reg.pix[k]) * aads_pkg::prod_t'(wa_reg);
            pb_reg[k] <= aads_pkg::prod_t'(cmd_reg.pix[k]) * aads_pkg::prod_t'(wb_reg);
        end
    end

    // Restoring divider for (2*acc + S) / (2*S), one quotient bit per cycle.
    always_ff @(posedge clk)
    begin
        if (emit_cap)
        begin
            dsh_reg <= DIVW'(s_prod) << aads_pkg::DIV_STEPS;
            for (int k = 0; k < aads_pkg::NUM_CH; k++)
            begin
                num_reg[k] <= (DIVW'(cur_sum[k]) << 1) + DIVW'(s_prod);
                q_reg[k] <= '0;
            end
        end
        else if (div_step)
        begin
            dsh_reg <= dsh_reg >> 1;
            for (int k = 0; k < aads_pkg::NUM_CH; k++)
            begin
                if (num_reg[k] >= dsh_reg)
                    num_reg[k] <= num_reg[k] - dsh_reg;
                q_reg[k] <= {q_reg[k][aads_pkg::DIV_STEPS-2:0], num_reg[k] >= dsh_reg};
            end
        end
    end

    // Output register with saturation to 255.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            for (int k = 0; k < aads_pkg::NUM_CH; k++)
                res_reg[k] <= (|q_reg[k][aads_pkg::DIV_STEPS-1:8]) ? 8'hFF : q_reg[k][7:0];
            out_col_reg <= cmd_reg.out_col;
            out_row_reg <= cmd_reg.out_row;
            out_last_reg <= cmd_reg.frame_last;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= aads_pkg::BK_CLEAR;
            clr_cnt_reg <= '0;
            div_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clear_start)
                clr_cnt_reg <= '0;
            else if (clearing)
                clr_cnt_reg <= clr_cnt_reg + IDXW'(1);
            if (emit_cap)
                div_cnt_reg <= 4'(aads_pkg::DIV_STEPS - 1);
            else if (div_step)
                div_cnt_reg <= div_cnt_reg - 4'd1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red = res_reg[0];
    assign out_green = res_reg[1];
    assign out_blue = res_reg[2];
    assign out_col = out_col_reg;
    assign out_row = out_row_reg;
    assign frame_last = out_last_reg;

endmodule

@@ sv/area_average_downscale_stream_unit.sv @@
// Top level of the area-averaging RGB downscaler.
//
//   Channel   Direction  Handshake            Payload
//   pixel in  input      in_valid/in_ready    pix_red, pix_green, pix_blue
//   result    output     out_valid/out_ready  out_red/green/blue, out_col, out_row, frame_last
//   config    input      cfg_wr_en            cfg_index, cfg_data
//
// A pixel passes the back-end states RD0, MUL0 and ADD0, then RD1, MUL1 and ADD1
// when it straddles two destination columns, then the divider and the output load
// when it completes a destination pixel; each bank's single memory port sets the
// read, multiply, write sequence. After reset and after every configuration write
// all MAX_DST_WIDTH entries of both accumulator banks are cleared, during which in_ready is low.
// A two-entry queue lets pixel transfers continue while a result waits on out_ready.
module area_average_downscale_stream_unit #(
    parameter int MAX_DST_WIDTH = 2048,
    parameter int MAX_SRC_DIM = 4096,
    parameter int ACC_BITS = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [12:0] cfg_data,
    input  logic in_valid,
    output logic in_ready,
    input  logic [7:0] pix_red,
    input  logic [7:0] pix_green,
    input  logic [7:0] pix_blue,
    output logic out_valid,
    input  logic out_ready,
    output logic [7:0] out_red,
    output logic [7:0] out_green,
    output logic [7:0] out_blue,
    output logic [10:0] out_col,
    output logic [10:0] out_row,
    output logic frame_last
);

    aads_pkg::cmd_t front_cmd, queue_cmd;
    aads_pkg::sprod_t s_prod;
    logic pix_accept, q_full, q_empty, q_pop, clearing;

    // Input transfer when the queue has room and no clearing pass runs.
    assign in_ready = !q_full && !clearing;
    assign pix_accept = in_valid && in_ready;

    aads_front #(
        .MAX_DST_WIDTH(MAX_DST_WIDTH),
        .MAX_SRC_DIM(MAX_SRC_DIM)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(aads_pkg::cfg_reg_t'(cfg_index)),
        .cfg_data(cfg_data),
        .pix_accept(pix_accept),
        .pix_red(pix_red),
        .pix_green(pix_green),
        .pix_blue(pix_blue),
        .cmd(front_cmd),
        .s_prod(s_prod)
    );

    aads_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(pix_accept),
        .push_data(front_cmd),
        .pop(q_pop),
        .pop_data(queue_cmd),
        .full(q_full),
        .empty(q_empty)
    );

    aads_back #(
        .MAX_DST_WIDTH(MAX_DST_WIDTH),
        .ACC_BITS(ACC_BITS)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .clear_start(cfg_wr_en),
        .q_empty(q_empty),
        .q_data(queue_cmd),
        .s_prod(s_prod),
        .q_pop(q_pop),
        .clearing(clearing),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_red(out_red),
        .out_green(out_green),
        .out_blue(out_blue),
        .out_col(out_col),
        .out_row(out_row),
        .frame_last(frame_last)
    );

endmodule

@@ tb/area_average_downscale_stream_unit_test.sv @@
// Self-checking testbench of the area-averaging RGB downscaler, with its scoreboard.
module area_average_downscale_stream_unit_test;

    localparam int MAX_DW = 2048;
    localparam int MAX_SD = 4096;
    localparam int ACC_W = 32;
    localparam int IDLE_LIMIT = 40000;
    localparam int DRAIN_CYCLES = 80;
    localparam int RANDOM_ITEMS = 1300;

    // One destination pixel as the block emits it.
    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [10:0] col;
        logic [10:0] row;
        logic last;
    } dst_pixel_t;

    // Scoreboard: tracks the downscaler state and holds the pixels still to come out.
    class downscale_scoreboard;
        longint unsigned reg_sw, reg_sh, reg_dw, reg_dh;
        longint unsigned cur_row[MAX_DW][3];
        longint unsigned nxt_row[MAX_DW][3];
        longint unsigned s_col, s_row, d_col, d_row, x_phase, y_phase;
        dst_pixel_t awaited[$];
        int errors;

        function new();
            reg_sw = aads_pkg::RST_SRC_WIDTH;
            reg_sh = aads_pkg::RST_SRC_HEIGHT;
            reg_dw = aads_pkg::RST_DST_WIDTH;
            reg_dh = aads_pkg::RST_DST_HEIGHT;
            errors = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < MAX_DW; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    cur_row[i][k] = 0;
                    nxt_row[i][k] = 0;
                end
            end
            s_col = 0;
            s_row = 0;
            d_col = 0;
            d_row = 0;
            x_phase = 0;
            y_phase = 0;
        endfunction

        function longint unsigned clampv(longint unsigned v, longint unsigned lo,
                                         longint unsigned hi);
            if (v < lo)
                return lo;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function longint unsigned col_slot(longint unsigned i);
            return (i >= MAX_DW) ? MAX_DW - 1 : i;
        endfunction

        function longint unsigned sat_add(longint unsigned a, longint unsigned v);
            longint unsigned lim;
            lim = (64'd1 << ACC_W) - 1;
            return (a + v > lim) ? lim : a + v;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // A register write restarts the frame.
        function void write_reg(aads_pkg::cfg_reg_t idx, logic [12:0] val);
            case (idx)
                aads_pkg::REG_SRC_WIDTH:  reg_sw = val;
                aads_pkg::REG_SRC_HEIGHT: reg_sh = val;
                aads_pkg::REG_DST_WIDTH:  reg_dw = val[11:0];
                aads_pkg::REG_DST_HEIGHT: reg_dh = val[11:0];
            endcase
            restart();
        endfunction

        // Accumulates one accepted source pixel and notes the destination pixel it completes.
        function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            longint unsigned sw, sh, dw, dh, xend, yend, wx0, wx1, wy0, wy1, c0, c1, s, q;
            longint unsigned pix[3];
            bit col_done, row_done, row_end, frame_end;
            dst_pixel_t res;
            sw = clampv(reg_sw, 1, MAX_SD);
            sh = clampv(reg_sh, 1, MAX_SD);
            dw = clampv(reg_dw, 1, MAX_DW);
            dh = clampv(reg_dh, 1, aads_pkg::DST_ROW_LIMIT);
            if (dw > sw)
                dw = sw;
            if (dh > sh)
                dh = sh;
            pix[0] = r;
            pix[1] = g;
            pix[2] = b;

            xend = x_phase + dw;
            col_done = xend >= sw;
            wx0 = (col_done ? sw : xend) - x_phase;
            wx1 = (xend > sw) ? xend - sw : 0;
            yend = y_phase + dh;
            row_done = yend >= sh;
            wy0 = (row_done ? sh : yend) - y_phase;
            wy1 = (yend > sh) ? yend - sh : 0;
            c0 = col_slot(d_col);
            c1 = col_slot(d_col + 1);

            // Spread the weighted color over up to four accumulators.
            for (int k = 0; k < 3; k++)
            begin
                cur_row[c0][k] = sat_add(cur_row[c0][k], pix[k] * wx0 * wy0);
                if (wx1 != 0)
                    cur_row[c1][k] = sat_add(cur_row[c1][k], pix[k] * wx1 * wy0);
                if (wy1 != 0)
                begin
                    nxt_row[c0][k] = sat_add(nxt_row[c0][k], pix[k] * wx0 * wy1);
                    if (wx1 != 0)
                        nxt_row[c1][k] = sat_add(nxt_row[c1][k], pix[k] * wx1 * wy1);
                end
            end

            row_end = s_col + 1 >= sw;
            frame_end = row_end && (s_row + 1 >= sh);

            // A finished destination pixel is rounded half up and saturated.
            if (col_done && row_done)
            begin
                s = sw * sh;
                for (int k = 0; k < 3; k++)
                begin
                    q = (2 * cur_row[c0][k] + s) / (2 * s);
                    pix[k] = (q > 255) ? 255 : q;
                    cur_row[c0][k] = 0;
                end
                res.red = 8'(pix[0]);
                res.green = 8'(pix[1]);
                res.blue = 8'(pix[2]);
                res.col = d_col[10:0];
                res.row = d_row[10:0];
                res.last = frame_end;
                awaited.push_back(res);
            end

            if (frame_end)
                restart();
            else if (row_end)
            begin
                s_col = 0;
                d_col = 0;
                x_phase = 0;
                s_row++;
                if (row_done)
                begin
                    for (int i = 0; i < MAX_DW; i++)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            cur_row[i][k] = nxt_row[i][k];
                            nxt_row[i][k] = 0;
                        end
                    end
                    d_row++;
                    y_phase = yend - sh;
                end
                else
                    y_phase = yend;
            end
            else
            begin
                s_col++;
                if (col_done)
                begin
                    d_col++;
                    x_phase = xend - sw;
                end
                else
                    x_phase = xend;
            end
        endfunction

        // Compares one emitted pixel with the oldest one awaited.
        function void check(dst_pixel_t got);
            dst_pixel_t exp_pix;
            if (awaited.size() == 0)
            begin
                $error("unexpected result at col %0d row %0d", got.col, got.row);
                errors++;
                return;
            end
            exp_pix = awaited.pop_front();
            if (got.red !== exp_pix.red)
            begin
                $error("out_red: expected %0d, got %0d", exp_pix.red, got.red);
                errors++;
            end
            if (got.green !== exp_pix.green)
            begin
                $error("out_green: expected %0d, got %0d", exp_pix.green, got.green);
                errors++;
            end
            if (got.blue !== exp_pix.blue)
            begin
                $error("out_blue: expected %0d, got %0d", exp_pix.blue, got.blue);
                errors++;
            end
            if (got.col !== exp_pix.col)
            begin
                $error("out_col: expected %0d, got %0d", exp_pix.col, got.col);
                errors++;
            end
            if (got.row !== exp_pix.row)
            begin
                $error("out_row: expected %0d, got %0d", exp_pix.row, got.row);
                errors++;
            end
            if (got.last !== exp_pix.last)
            begin
                $error("frame_last: expected %0d, got %0d", exp_pix.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [12:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [7:0] pix_red = '0;
    logic [7:0] pix_green = '0;
    logic [7:0] pix_blue = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [10:0] out_col;
    logic [10:0] out_row;
    logic frame_last;

    downscale_scoreboard sb = new();
    bit hold_request = 1'b0;
    bit in_gaps_on = 1'b1;
    bit out_gaps_on = 1'b1;
    int idle_cycles = 0;
    int sent_items = 0;

    area_average_downscale_stream_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .pix_red(pix_red),
        .pix_green(pix_green),
        .pix_blue(pix_blue),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_red(out_red),
        .out_green(out_green),
        .out_blue(out_blue),
        .out_col(out_col),
        .out_row(out_row),
        .frame_last(frame_last)
    );

    always #6 clk = ~clk;

    // Random gap length: mostly short, now and then long.
    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 80);
        return $urandom_range(1, 3);
    endfunction

    // Color component that favors the extremes.
    function automatic logic [7:0] color_value();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Result side: random back-pressure, a long hold-off on request, and checking.
    always @(posedge clk)
    begin
        dst_pixel_t got;
        if (out_valid && out_ready)
        begin
            got.red = out_red;
            got.green = out_green;
            got.blue = out_blue;
            got.col = out_col;
            got.row = out_row;
            got.last = frame_last;
            sb.check(got);
        end
    end

    initial
    begin
        int n;
        wait (rst_n);
        forever
        begin
            if (hold_request)
            begin
                out_ready <= 1'b0;
                hold_request = 1'b0;
                repeat (600) @(posedge clk);
            end
            else if (out_gaps_on && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                n = gap_len();
                repeat (n) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // One register write on the configuration port.
    task automatic write_reg(aads_pkg::cfg_reg_t idx, logic [12:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_sizes(logic [12:0] sw, logic [12:0] sh, logic [12:0] dw, logic [12:0] dh);
        write_reg(aads_pkg::REG_SRC_WIDTH, sw);
        write_reg(aads_pkg::REG_SRC_HEIGHT, sh);
        write_reg(aads_pkg::REG_DST_WIDTH, dw);
        write_reg(aads_pkg::REG_DST_HEIGHT, dh);
    endtask

    // Offers one pixel and waits for its transfer.
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int n;
        if (in_gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            n = gap_len();
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        pix_red <= r;
        pix_green <= g;
        pix_blue <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_pixel(r, g, b);
        sent_items++;
    endtask

    task automatic send_random(int count);
        for (int i = 0; i < count; i++)
            send_pixel(color_value(), color_value(), color_value());
        in_valid <= 1'b0;
    endtask

    // Waits until every awaited pixel is out and the pipeline has drained.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int sw, sh, dw, dh, nregs;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset sizes: a few pixels that complete nothing.
        send_random(4);
        settle();

        // Four to one with extreme colors.
        set_sizes(4, 4, 2, 2);
        for (int i = 0; i < 16; i++)
            send_pixel((i % 2) ? 8'd255 : 8'd0, (i % 3) ? 8'd255 : 8'd0, 8'd255);
        settle();

        // One to one: every pixel ends a frame.
        set_sizes(1, 1, 1, 1);
        send_pixel(8'd255, 8'd0, 8'd128);
        send_pixel(8'd0, 8'd255, 8'd1);
        settle();

        // Zero sizes clamp to one; oversized destination clamps to source.
        set_sizes(0, 0, 0, 0);
        send_random(2);
        settle();
        set_sizes(5, 3, 8191, 4095);
        send_random(16);
        settle();

        // Straddling columns.
        set_sizes(3, 2, 2, 1);
        send_random(7);
        settle();

        // Widest rows: only a part of the first one.
        set_sizes(8191, 1, 2048, 1);
        send_random(40);
        settle();
        set_sizes(4096, 4096, 4096, 4096);
        send_random(20);
        settle();

        // Receiver holds off while pixels keep coming.
        set_sizes(1, 1, 1, 1);
        in_gaps_on = 1'b0;
        hold_request = 1'b1;
        send_random(40);
        settle();
        in_gaps_on = 1'b1;

        // Random sizes, mostly whole frames.
        while (sent_items < RANDOM_ITEMS)
        begin
            sw = $urandom_range(1, 10);
            sh = $urandom_range(1, 6);
            dw = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 12) : $urandom_range(1, sw);
            dh = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8) : $urandom_range(1, sh);
            nregs = $urandom_range(1, 4);
            if (nregs == 4)
                set_sizes(13'(sw), 13'(sh), 13'(dw), 13'(dh));
            else
            begin
                for (int i = 0; i < nregs; i++)
                begin
                    case ($urandom_range(0, 3))
                        0: write_reg(aads_pkg::REG_SRC_WIDTH, 13'(sw));
                        1: write_reg(aads_pkg::REG_SRC_HEIGHT, 13'(sh));
                        2: write_reg(aads_pkg::REG_DST_WIDTH, 13'(dw));
                        default: write_reg(aads_pkg::REG_DST_HEIGHT, 13'(dh));
                    endcase
                end
            end
            in_gaps_on = ($urandom_range(0, 4) != 0);
            out_gaps_on = ($urandom_range(0, 4) != 0);
            send_random(sw * sh * $urandom_range(1, 3) + $urandom_range(0, sw));
            settle();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
